// ===== hw/rtl/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants of the polynomial key-share evaluator.
// ----------------------------------------------------------------------------
package psm_pkg;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned ACC_W    = 33;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned S_DATA_W = 72;

	localparam logic [16:0] PRIME_F4 = 17'h1_0001;
	localparam logic [16:0] PRIME_16 = 17'h0_FFF1;
	localparam logic [32:0] PRIME_F5 = 33'h1_0000_0001;

	typedef enum logic [MODE_W-1:0] {
		MODE_F4 = 2'd0,
		MODE_16 = 2'd1,
		MODE_F5 = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FIELD_F4,
		FIELD_16,
		FIELD_F5
	} field_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_EVAL  = 1'b1
	} req_t;

	typedef struct packed {
		logic   mul_en;
		field_t field;
	} step_ctrl_t;

endpackage

// ===== hw/rtl/polynomial_share_mod_prime.sv =====
// ----------------------------------------------------------------------------
// polynomial_share_mod_prime
// Evaluates a stored key polynomial at a peer id modulo 65537, 65521 or
// 2^32+1.
// ----------------------------------------------------------------------------
// A coefficient write word is taken while idle and gives no output word. An
// evaluate word runs the Horner loop and then has its key share loaded into
// the output register; no further input word is taken until that load has
// returned the block to idle. In the Horner loop each coefficient passes the
// shared multiply-reduce unit as a multiply and then a reduce, with the
// coefficient memory read overlapped, and a final step loads the output
// register. A finished key share waits in the output register while new words
// are taken; an evaluation that finishes while it is still occupied holds
// until it is taken. The user must write the modulus mode register through
// the cfg channel only while idle; the block itself does not enforce this.
module polynomial_share_mod_prime #(
	parameter int unsigned NUM_COEFFS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psm_pkg::MODE_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// coeff_index [3:0], coeff_value [35:4], node_id [67:36], zero [71:68]
	input  logic [psm_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type [0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// key_share [31:0]
	output logic [psm_pkg::KEY_W-1:0]     m_tdata
);

	localparam int unsigned AW = $clog2(NUM_COEFFS);
	localparam int unsigned IW = (AW > psm_pkg::IDX_W) ? AW : psm_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	state_t                     state_q;
	logic                       ph_q;
	logic [AW-1:0]              k_q;
	logic [psm_pkg::MODE_W-1:0] modulus_mode_q;
	psm_pkg::field_t            field_q;
	logic [psm_pkg::ACC_W-1:0]  acc_q;
	logic [psm_pkg::KEY_W-1:0]  x_q;
	logic                       m_tvalid_q;
	logic [psm_pkg::KEY_W-1:0]  m_tdata_q;

	logic [psm_pkg::IDX_W-1:0]  coeff_index;
	logic [psm_pkg::KEY_W-1:0]  coeff_value;
	logic [psm_pkg::KEY_W-1:0]  node_id;
	logic [IW-1:0]              idx_w;
	logic                       s_acc;
	logic                       eval_acc;
	logic                       wr_en;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [psm_pkg::KEY_W-1:0]  rd_data;
	logic [psm_pkg::ACC_W-1:0]  red;
	psm_pkg::field_t            field_d;
	psm_pkg::step_ctrl_t        ctrl;
	logic                       out_free;
	logic                       out_load;

	assign coeff_index = s_tdata[3:0];
	assign coeff_value = s_tdata[35:4];
	assign node_id     = s_tdata[67:36];
	assign idx_w       = IW'(coeff_index);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign eval_acc  = s_acc && (s_tuser == psm_pkg::REQ_EVAL);
	assign wr_en     = s_acc && (s_tuser == psm_pkg::REQ_WRITE)
	                   && (32'(coeff_index) < NUM_COEFFS);
	assign rd_en     = eval_acc || ((state_q == ST_RUN) && ph_q && (k_q != '0));
	assign rd_addr   = (state_q == ST_IDLE) ? AW'(NUM_COEFFS - 1) : (k_q - 1'b1);
	assign out_free  = !m_tvalid_q || m_tready;
	assign out_load  = (state_q == ST_FIN) && out_free;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		unique case (modulus_mode_q)
			psm_pkg::MODE_F4: field_d = psm_pkg::FIELD_F4;
			psm_pkg::MODE_16: field_d = psm_pkg::FIELD_16;
			default:          field_d = psm_pkg::FIELD_F5;
		endcase
	end

	assign ctrl.mul_en = (state_q == ST_RUN) && !ph_q;
	assign ctrl.field  = field_q;

	psm_coef_mem #(
		.DEPTH (NUM_COEFFS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_w[AW-1:0]),
		.wr_data (coeff_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psm_mulred u_mulred (
		.clk  (clk),
		.ctrl (ctrl),
		.acc  (acc_q),
		.x    (x_q),
		.coef (rd_data),
		.red  (red)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ph_q           <= 1'b0;
			k_q            <= '0;
			modulus_mode_q <= psm_pkg::MODE_F4;
			field_q        <= psm_pkg::FIELD_F4;
			acc_q          <= '0;
			x_q            <= '0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				modulus_mode_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (eval_acc) begin
						state_q <= ST_RUN;
						ph_q    <= 1'b0;
						k_q     <= AW'(NUM_COEFFS - 1);
						acc_q   <= '0;
						field_q <= field_d;
						if (field_d == psm_pkg::FIELD_F5) begin
							x_q <= node_id;
						end else begin
							x_q <= {16'b0, node_id[15:0]};
						end
					end
				end
				ST_RUN: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						acc_q <= red;
						if (k_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							k_q <= k_q - 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						if (field_q == psm_pkg::FIELD_F5) begin
							m_tdata_q <= acc_q[psm_pkg::KEY_W-1:0];
						end else begin
							m_tdata_q <= {16'b0, acc_q[15:0]};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/psm_coef_mem.sv =====
// ----------------------------------------------------------------------------
// psm_coef_mem
// Coefficient store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psm_coef_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [psm_pkg::KEY_W-1:0]  wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [psm_pkg::KEY_W-1:0]  rd_data
);

	logic [psm_pkg::KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/psm_mulred.sv =====
// ----------------------------------------------------------------------------
// psm_mulred
// One Horner step: registered multiply of the accumulator by the point plus
// the coefficient, then a fold-and-correct reduction for the selected prime.
// ----------------------------------------------------------------------------
module psm_mulred (
	input  logic                       clk,
	input  psm_pkg::step_ctrl_t        ctrl,
	input  logic [psm_pkg::ACC_W-1:0]  acc,
	input  logic [psm_pkg::KEY_W-1:0]  x,
	input  logic [psm_pkg::KEY_W-1:0]  coef,
	output logic [psm_pkg::ACC_W-1:0]  red
);

	logic [63:0]               prod_s1;
	logic [psm_pkg::KEY_W-1:0] c_s1;
	psm_pkg::field_t           field_s1;

	logic [63:0]               prod_d;
	logic [psm_pkg::KEY_W-1:0] c_d;

	always_comb begin
		if (acc[psm_pkg::ACC_W-1]) begin
			prod_d = 64'(psm_pkg::PRIME_F5) - 64'(x);
		end else begin
			prod_d = acc[psm_pkg::KEY_W-1:0] * x;
		end
		if (ctrl.field == psm_pkg::FIELD_F5) begin
			c_d = coef;
		end else begin
			c_d = {16'b0, coef[15:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1  <= prod_d;
			c_s1     <= c_d;
			field_s1 <= ctrl.field;
		end
	end

	logic [63:0] v;
	logic [33:0] t_f5;
	logic [17:0] t_f4;
	logic [20:0] f1;
	logic [16:0] f2;

	always_comb begin
		v    = prod_s1 + 64'(c_s1);
		t_f5 = {2'b0, v[31:0]} - {2'b0, v[63:32]};
		if (t_f5[33]) begin
			t_f5 = t_f5 + 34'(psm_pkg::PRIME_F5);
		end
		t_f4 = {2'b0, v[15:0]} - {2'b0, v[31:16]};
		if (t_f4[17]) begin
			t_f4 = t_f4 + 18'(psm_pkg::PRIME_F4);
		end
		f1 = 21'({v[31:16], 4'b0}) - 21'(v[31:16]) + 21'(v[15:0]);
		f2 = 17'({f1[20:16], 4'b0}) - 17'(f1[20:16]) + 17'(f1[15:0]);
		if (f2 >= psm_pkg::PRIME_16) begin
			f2 = f2 - psm_pkg::PRIME_16;
		end
		case (field_s1)
			psm_pkg::FIELD_F4: red = 33'(t_f4[16:0]);
			psm_pkg::FIELD_16: red = 33'(f2);
			default:           red = t_f5[32:0];
		endcase
	end

endmodule

// ===== hw/rtl/psm_checker.sv =====
// ----------------------------------------------------------------------------
// psm_checker
// Port-level checks of the polynomial key-share evaluator, bound to the top.
// ----------------------------------------------------------------------------
module psm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [psm_pkg::KEY_W-1:0]     m_tdata
);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word dropped or changed while stalled");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == psm_pkg::REQ_WRITE) && !m_tvalid |=> !m_tvalid)
		else $error("coefficient write produced an output word");

	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == psm_pkg::REQ_EVAL) |=> !s_tready)
		else $error("input taken during an evaluation");

	a_eval_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_tuser == psm_pkg::REQ_EVAL) && !m_tvalid |=> !m_tvalid)
		else $error("key share appeared in the cycle after its request");

endmodule

bind polynomial_share_mod_prime psm_checker u_psm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
